@@ rtl/spp_pkg.sv @@
`timescale 1ns / 1ps
package spp_pkg;
   localparam int MaxSide = 64;
   localparam int SinePeriod = 85;

   typedef enum logic [2:0] {
      REG_MODE = 3'd0, REG_SIDE = 3'd1, REG_NRATE = 3'd2,
      REG_RA = 3'd3, REG_RB = 3'd4, REG_RC = 3'd5, REG_RD = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_DIV, BK_ACC, BK_OUT
   } back_state_type;

   // one classified operation from the front to the back
   typedef struct packed {
      logic        pixel;
      logic        ring_mode;
      logic [5:0]  column;
      logic [5:0]  row;
      logic [15:0] frame_time;
   } op_type;

   function automatic logic signed [7:0] sine_lookup(input logic [7:0] idx);
      logic [6:0] p;
      logic signed [7:0] t [0:84];
      t = '{8'sd0, 8'sd9, 8'sd18, 8'sd28, 8'sd37, 8'sd46, 8'sd54, 8'sd63, 8'sd71, 8'sd79,
         8'sd86, 8'sd92, 8'sd99, 8'sd104, 8'sd110, 8'sd114, 8'sd118, 8'sd121, 8'sd124,
         8'sd126, 8'sd127, 8'sd127, 8'sd127, 8'sd126, 8'sd125, 8'sd123, 8'sd120, 8'sd116,
         8'sd112, 8'sd107, 8'sd102, 8'sd96, 8'sd89, 8'sd82, 8'sd75, 8'sd67, 8'sd59, 8'sd50,
         8'sd41, 8'sd32, 8'sd23, 8'sd14, 8'sd4, -8'sd4, -8'sd14, -8'sd23, -8'sd32, -8'sd41,
         -8'sd50, -8'sd59, -8'sd67, -8'sd75, -8'sd82, -8'sd89, -8'sd96, -8'sd102, -8'sd107,
         -8'sd112, -8'sd116, -8'sd120, -8'sd123, -8'sd125, -8'sd126, -8'sd127, -8'sd127,
         -8'sd127, -8'sd126, -8'sd124, -8'sd121, -8'sd118, -8'sd114, -8'sd110, -8'sd104,
         -8'sd99, -8'sd92, -8'sd86, -8'sd79, -8'sd71, -8'sd63, -8'sd54, -8'sd46, -8'sd37,
         -8'sd28, -8'sd18, -8'sd9};
      if (idx >= 8'd170) p = 7'(idx - 8'd170);
      else if (idx >= 8'd85) p = 7'(idx - 8'd85);
      else p = idx[6:0];
      return t[p];
   endfunction
endpackage

@@ rtl/spp_queue.sv @@
`timescale 1ns / 1ps
module spp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  spp_pkg::op_type push_data,
   output logic            full,
   input  logic            pop,
   output spp_pkg::op_type pop_data,
   output logic            empty
);
   spp_pkg::op_type mem_ff [0:1];
   logic wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];
   assign wr_in = wr_ff ^ do_push;
   assign rd_in = rd_ff ^ do_pop;
   assign cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end
endmodule

@@ rtl/spp_divider.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle: 255*d2 (21 bits) by maxd2
module spp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [20:0] dividend,
   input  logic [11:0] divisor,
   output logic        done,
   output logic [7:0]  quotient
);
   logic [20:0] q_ff, q_in;
   logic [11:0] r_ff, r_in;
   logic [11:0] d_ff;
   logic [4:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [12:0] trial;

   always_comb begin
      trial = {r_ff, q_ff[20]};
      q_in = {q_ff[19:0], 1'b0};
      r_in = trial[11:0];
      if (trial >= {1'b0, d_ff}) begin
         r_in = 12'(trial - {1'b0, d_ff});
         q_in[0] = 1'b1;
      end
      n_in = n_ff - 5'd1;
      busy_in = busy_ff && n_ff != 5'd1;
   end

   assign done = busy_ff && n_ff == 5'd1;
   always_comb begin
      if (q_in[20:8] != 13'd0) quotient = 8'hFF;
      else quotient = q_in[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else if (start) busy_ff <= 1'b1;
      else busy_ff <= busy_in;
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
         n_ff <= 5'd21;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
         n_ff <= n_in;
      end
   end
endmodule

@@ rtl/spp_back.sv @@
`timescale 1ns / 1ps
module spp_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  spp_pkg::op_type op,
   output logic            op_take,
   input  logic [6:0]      side,
   input  logic [15:0]     normal_rate,
   input  logic [31:0]     ring_rates,
   output logic            out_valid,
   output logic signed [7:0] out_value,
   input  logic            out_take
);
   spp_pkg::back_state_type st_ff, st_in;
   logic [23:0] single_ff;
   logic [23:0] ring_ff [0:3];
   logic [1:0]  idx_ff, idx_in;
   logic signed [9:0] sum_ff, sum_in;
   logic [7:0]  val_ff;
   logic        full_ff;
   logic        div_start, div_done;
   logic [7:0]  dq;
   logic [5:0]  hh, mask, x, cx, cy;
   logic signed [7:0] dx, dy;
   logic [15:0] dxx, dyy;
   logic [12:0] d2;
   logic [11:0] maxd2;
   logic [20:0] prod;
   logic [20:0] dividend;
   logic [7:0]  ph, sine_idx;
   logic [5:0]  ox, oy;
   logic [31:0] sprod;
   logic [23:0] rinc;
   logic [6:0]  s;

   always_comb begin
      if (side < 7'd2) s = 7'd2;
      else if (side > 7'(spp_pkg::MaxSide)) s = 7'(spp_pkg::MaxSide);
      else s = side;
   end
   assign hh = 6'(s >> 1);
   assign mask = 6'(s - 7'd1);
   assign x = 6'(s - 7'd1 - {1'b0, op.column});
   always_comb begin
      case (idx_ff)
         2'd0: begin ox = 6'd6; oy = 6'd10; end
         2'd1: begin ox = 6'd13; oy = 6'd3; end
         2'd2: begin ox = 6'd17; oy = 6'd1; end
         default: begin ox = 6'd31; oy = 6'd22; end
      endcase
      if (op.ring_mode) begin
         cx = (x + ox) & mask;
         cy = (op.row + oy) & mask;
      end else begin
         cx = op.column;
         cy = op.row;
      end
      dx = 8'($signed({2'b0, cx})) - 8'($signed({2'b0, hh}));
      dy = 8'($signed({2'b0, cy})) - 8'($signed({2'b0, hh}));
      dxx = 16'($signed({{8{dx[7]}}, dx}) * $signed({{8{dx[7]}}, dx}));
      dyy = 16'($signed({{8{dy[7]}}, dy}) * $signed({{8{dy[7]}}, dy}));
      d2 = 13'(dxx) + 13'(dyy);
      maxd2 = 12'({hh, 1'b0}) * 12'(hh);
      prod = 21'(d2) * 21'd255;
      dividend = prod;
      ph = op.ring_mode ? ring_ff[idx_ff][23:16] : single_ff[23:16];
      sine_idx = dq + ph;
   end

   spp_divider u_div (.clock(clock), .reset(reset), .start(div_start),
      .dividend(dividend), .divisor(maxd2), .done(div_done), .quotient(dq));

   assign sprod = 32'(normal_rate) * 32'(op.frame_time);
   assign rinc = 24'(ring_rates[8*idx_ff +: 8]) * 24'(op.frame_time);

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      op_take = 1'b0;
      div_start = 1'b0;
      case (st_ff)
         spp_pkg::BK_IDLE: begin
            if (op_valid) begin
               if (!op.pixel) begin
                  if (!op.ring_mode || idx_ff == 2'd3) begin
                     op_take = 1'b1;
                     idx_in = 2'd0;
                  end else idx_in = idx_ff + 2'd1;
               end else if (!full_ff) begin
                  div_start = 1'b1;
                  st_in = spp_pkg::BK_DIV;
               end
            end
         end
         spp_pkg::BK_DIV: begin
            if (div_done) begin
               sum_in = sum_ff + 10'(spp_pkg::sine_lookup(sine_idx));
               st_in = spp_pkg::BK_ACC;
            end
         end
         spp_pkg::BK_ACC: begin
            // advance to the next ring (idle restarts the divider with its offsets), else output
            if (op.ring_mode && idx_ff != 2'd3) begin
               idx_in = idx_ff + 2'd1;
               st_in = spp_pkg::BK_IDLE;
            end else st_in = spp_pkg::BK_OUT;
         end
         default: begin
            op_take = 1'b1;
            idx_in = 2'd0;
            sum_in = '0;
            st_in = spp_pkg::BK_IDLE;
         end
      endcase
   end

   assign out_valid = full_ff;
   assign out_value = $signed(val_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= spp_pkg::BK_IDLE;
         idx_ff <= 2'd0;
         sum_ff <= '0;
         full_ff <= 1'b0;
         single_ff <= '0;
         ring_ff[0] <= 24'h000000;
         ring_ff[1] <= 24'h010000;
         ring_ff[2] <= 24'h040000;
         ring_ff[3] <= 24'h030000;
      end else begin
         st_ff <= st_in;
         idx_ff <= idx_in;
         sum_ff <= sum_in;
         if (st_ff == spp_pkg::BK_OUT) begin
            full_ff <= 1'b1;
            val_ff <= op.ring_mode ? 8'(sum_ff >>> 2) : 8'(sum_ff);
         end else if (out_take) full_ff <= 1'b0;
         if (st_ff == spp_pkg::BK_IDLE && op_valid && !op.pixel) begin
            if (op.ring_mode) ring_ff[idx_ff] <= ring_ff[idx_ff] + rinc;
            else single_ff <= single_ff + sprod[31:8];
         end
      end
   end
endmodule

@@ rtl/spp_front.sv @@
`timescale 1ns / 1ps
module spp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [4:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   input  logic            action,
   input  logic [5:0]      column,
   input  logic [5:0]      row,
   input  logic [15:0]     frame_time,
   output spp_pkg::op_type op,
   output logic [6:0]      side,
   output logic [15:0]     normal_rate,
   output logic [31:0]     ring_rates
);
   logic        mode_ff;
   logic [6:0]  side_ff;
   logic [15:0] nrate_ff;
   logic [31:0] rr_ff;
   spp_pkg::reg_index_type ri;

   assign ri = spp_pkg::reg_index_type'(paddr[4:2]);
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         side_ff <= 7'd16;
         nrate_ff <= 16'd256;
         rr_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (ri)
            spp_pkg::REG_MODE: mode_ff <= pwdata[0];
            spp_pkg::REG_SIDE: side_ff <= pwdata[6:0];
            spp_pkg::REG_NRATE: nrate_ff <= pwdata[15:0];
            spp_pkg::REG_RA: rr_ff[7:0] <= pwdata[7:0];
            spp_pkg::REG_RB: rr_ff[15:8] <= pwdata[7:0];
            spp_pkg::REG_RC: rr_ff[23:16] <= pwdata[7:0];
            spp_pkg::REG_RD: rr_ff[31:24] <= pwdata[7:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (ri)
         spp_pkg::REG_MODE: prdata = {31'd0, mode_ff};
         spp_pkg::REG_SIDE: prdata = {25'd0, side_ff};
         spp_pkg::REG_NRATE: prdata = {16'd0, nrate_ff};
         spp_pkg::REG_RA: prdata = {24'd0, rr_ff[7:0]};
         spp_pkg::REG_RB: prdata = {24'd0, rr_ff[15:8]};
         spp_pkg::REG_RC: prdata = {24'd0, rr_ff[23:16]};
         spp_pkg::REG_RD: prdata = {24'd0, rr_ff[31:24]};
         default: prdata = '0;
      endcase
   end
   // classify the beat and tag it with the mode at acceptance
   assign op = '{pixel: action, ring_mode: mode_ff, column: column, row: row,
                 frame_time: frame_time};
   assign side = side_ff;
   assign normal_rate = nrate_ff;
   assign ring_rates = rr_ff;
endmodule

@@ rtl/sine_plasma_pixel_generator.sv @@
`timescale 1ns / 1ps
// Plasma pixel generator. An advance beat updates the single phase in single mode and
// the four ring phases in turn in four-ring mode; a pixel beat passes through the
// bit-serial distance divider once in single mode and once per ring lookup in four-ring
// mode. A two-entry queue between the front and the back lets new beats be taken while
// a pixel is computed; one result is held until popped.
module sine_plasma_pixel_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_action,
   input  logic [5:0]        req_column,
   input  logic [5:0]        req_row,
   input  logic [15:0]       req_frame_time,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic signed [7:0] rsp_pixel_value,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   spp_pkg::op_type fop, bop;
   logic q_empty, take, ov;
   logic [6:0] side;
   logic [15:0] nrate;
   logic [31:0] rrates;

   assign csr_pready = 1'b1;

   spp_front u_front (.clock(clock), .reset(reset), .psel(csr_psel),
      .penable(csr_penable), .pwrite(csr_pwrite), .paddr(csr_paddr),
      .pwdata(csr_pwdata), .prdata(csr_prdata), .action(req_action),
      .column(req_column), .row(req_row), .frame_time(req_frame_time), .op(fop),
      .side(side), .normal_rate(nrate), .ring_rates(rrates));

   spp_queue u_queue (.clock(clock), .reset(reset), .push(req_push),
      .push_data(fop), .full(req_full), .pop(take), .pop_data(bop), .empty(q_empty));

   spp_back u_back (.clock(clock), .reset(reset), .op_valid(!q_empty), .op(bop),
      .op_take(take), .side(side), .normal_rate(nrate), .ring_rates(rrates),
      .out_valid(ov), .out_value(rsp_pixel_value), .out_take(rsp_pop));

   assign rsp_empty = !ov;

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      take |-> !q_empty) else $error("queue popped while empty");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_pixel_value))
      else $error("result dropped");
endmodule
